/* rtl/core/cube_map_bilinear_sampler_assert.svh */
// Assertion macros shared by the cube map sampler RTL.
`ifndef CUBE_MAP_BILINEAR_SAMPLER_ASSERT_SVH
`define CUBE_MAP_BILINEAR_SAMPLER_ASSERT_SVH
`ifndef SYNTH
`define CMBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CMBS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define CMBS_ASSERT(lbl, prop, msg)
`define CMBS_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/core/cmbs_pkg.sv */
// Shared constants, codes and types of the cube map sampler.
package cmbs_pkg;

    localparam int MAX_FACE_SIZE = 16;
    localparam int CH_BITS       = 16;
    localparam int STRIDE_MAX    = MAX_FACE_SIZE + 2;
    localparam int STORE_DEPTH   = 6 * STRIDE_MAX * STRIDE_MAX;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int TEXEL_W       = 3 * CH_BITS;
    localparam int DIV_STEPS     = 17;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_POS,
        FE_PUSH
    } t_fe_state;

    typedef enum logic {
        BE_IDLE,
        BE_RUN
    } t_be_state;

    // One queued job: a texel write or a fully resolved sample.
    typedef struct packed {
        logic        is_sample;
        logic        wr_ok;
        logic [2:0]  face;
        logic [16:0] u;
        logic [16:0] v;
        logic [4:0]  x0;     // column for a write, base column for a sample
        logic [4:0]  y0;     // row for a write, base row for a sample
        logic [15:0] fx;
        logic [15:0] fy;
        logic [4:0]  stride;
        logic [TEXEL_W-1:0] texel;
    } t_job;

endpackage

/* rtl/core/cmbs_front.sv */
// Front end: accepts requests; for a sample picks the face, divides for u and v, resolves texel position.
`include "cube_map_bilinear_sampler_assert.svh"
module cmbs_front import cmbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [2:0]         i_write_face,
    input  logic [4:0]         i_write_col,
    input  logic [4:0]         i_write_row,
    input  logic [TEXEL_W-1:0] i_texel,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  logic [4:0]         i_face_size,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output t_job               o_job
);

    function automatic logic [20:0] axis_pos(input logic [16:0] c, input logic [4:0] n);
        logic [21:0]        prod;
        logic signed [23:0] x;
        logic signed [23:0] hi;
        prod = 22'(c) * 22'(n);
        x    = signed'({2'b00, prod}) - 24'sd32768;
        hi   = signed'({3'b000, n, 16'h0000}) - 24'sd66;
        if (x < -24'sd65536) begin
            x = -24'sd65536;
        end
        if (x > hi) begin
            x = hi;
        end
        x = x + 24'sd65536;
        return x[20:0];
    endfunction

    t_fe_state r_state, n_state;
    t_job      r_job, n_job;
    logic [2:0]  r_face, n_face;
    logic        r_zero, n_zero;
    logic [17:0] r_den, n_den;
    logic [17:0] r_rem_u, n_rem_u, r_rem_v, n_rem_v;
    logic [16:0] r_low_u, n_low_u, r_low_v, n_low_v;
    logic [16:0] r_qu, n_qu, r_qv, n_qv;
    logic [4:0]  r_cnt, n_cnt;

    logic [4:0]  w_n;
    logic        w_accept;
    logic signed [17:0] w_ex, w_ey, w_ez, w_num_u, w_num_v, w_m_s, w_sum_u, w_sum_v;
    logic [16:0] w_ax, w_ay, w_az, w_m;
    logic [33:0] w_nu, w_nv;
    logic [17:0] w_tu, w_tv;
    logic        w_geu, w_gev;
    logic [16:0] w_u, w_v;
    logic [20:0] w_pu, w_pv;

    assign w_n = (i_face_size == 5'd0) ? 5'd1 :
                 (i_face_size > 5'(MAX_FACE_SIZE)) ? 5'(MAX_FACE_SIZE) : i_face_size;
    assign w_accept = i_valid && o_ready;

    // face choice and dividend set-up
    always_comb begin
        w_ex = 18'(i_dir_x);
        w_ey = 18'(i_dir_y);
        w_ez = 18'(i_dir_z);
        w_ax = i_dir_x[15] ? 17'(-w_ex) : 17'(w_ex);
        w_ay = i_dir_y[15] ? 17'(-w_ey) : 17'(w_ey);
        w_az = i_dir_z[15] ? 17'(-w_ez) : 17'(w_ez);
        priority if (w_ax >= w_ay && w_ax >= w_az) begin
            w_m     = w_ax;
            n_face  = (i_dir_x > 0) ? FACE_PX : FACE_NX;
            w_num_u = (i_dir_x > 0) ? -w_ez : w_ez;
            w_num_v = -w_ey;
        end else if (w_ay >= w_az) begin
            w_m     = w_ay;
            n_face  = (i_dir_y > 0) ? FACE_PY : FACE_NY;
            w_num_u = w_ex;
            w_num_v = (i_dir_y > 0) ? w_ez : -w_ez;
        end else begin
            w_m     = w_az;
            n_face  = (i_dir_z > 0) ? FACE_PZ : FACE_NZ;
            w_num_u = (i_dir_z > 0) ? w_ex : -w_ex;
            w_num_v = -w_ey;
        end
        w_m_s   = signed'({1'b0, w_m});
        w_sum_u = w_num_u + w_m_s;
        w_sum_v = w_num_v + w_m_s;
        w_nu    = {1'b0, w_sum_u[16:0], 16'h0000} + 34'(w_m);
        w_nv    = {1'b0, w_sum_v[16:0], 16'h0000} + 34'(w_m);
    end

    // one restoring step per lane
    assign w_tu  = {r_rem_u[16:0], r_low_u[16]};
    assign w_tv  = {r_rem_v[16:0], r_low_v[16]};
    assign w_geu = w_tu >= r_den;
    assign w_gev = w_tv >= r_den;

    assign w_u  = r_zero ? 17'd32768 : r_qu;
    assign w_v  = r_zero ? 17'd32768 : r_qv;
    assign w_pu = axis_pos(w_u, w_n);
    assign w_pv = axis_pos(w_v, w_n);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FE_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req_type == REQ_SAMPLE) ? FE_DIV : FE_PUSH;
                end
            end
            FE_DIV: begin
                if (r_cnt == 5'd1) begin
                    n_state = FE_POS;
                end
            end
            FE_POS:  n_state = FE_PUSH;
            FE_PUSH: begin
                if (i_job_ready) begin
                    n_state = FE_IDLE;
                end
            end
            default: n_state = FE_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_job   = r_job;
        n_zero  = r_zero;
        n_den   = r_den;
        n_rem_u = r_rem_u;
        n_rem_v = r_rem_v;
        n_low_u = r_low_u;
        n_low_v = r_low_v;
        n_qu    = r_qu;
        n_qv    = r_qv;
        n_cnt   = r_cnt;
        if (r_state == FE_IDLE && w_accept) begin
            n_zero  = (w_m == 17'd0);
            n_den   = {w_m, 1'b0};
            n_rem_u = {1'b0, w_nu[33:17]};
            n_rem_v = {1'b0, w_nv[33:17]};
            n_low_u = w_nu[16:0];
            n_low_v = w_nv[16:0];
            n_cnt   = 5'(DIV_STEPS);
            n_job           = '0;
            n_job.is_sample = (i_req_type == REQ_SAMPLE);
            n_job.face      = i_write_face;
            n_job.x0        = i_write_col;
            n_job.y0        = i_write_row;
            n_job.texel     = i_texel;
            n_job.stride    = w_n + 5'd2;
            n_job.wr_ok     = (i_write_face <= FACE_NZ) && (i_write_col <= w_n + 5'd1)
                              && (i_write_row <= w_n + 5'd1);
        end
        if (r_state == FE_DIV) begin
            n_rem_u = w_geu ? (w_tu - r_den) : w_tu;
            n_rem_v = w_gev ? (w_tv - r_den) : w_tv;
            n_low_u = {r_low_u[15:0], 1'b0};
            n_low_v = {r_low_v[15:0], 1'b0};
            n_qu    = {r_qu[15:0], w_geu};
            n_qv    = {r_qv[15:0], w_gev};
            n_cnt   = r_cnt - 5'd1;
        end
        if (r_state == FE_POS) begin
            n_job.face = r_face;
            n_job.u    = w_u;
            n_job.v    = w_v;
            n_job.x0   = w_pu[20:16];
            n_job.y0   = w_pv[20:16];
            n_job.fx   = w_pu[15:0];
            n_job.fy   = w_pv[15:0];
        end
    end

    // outputs
    always_comb begin
        o_ready     = (r_state == FE_IDLE);
        o_job_valid = (r_state == FE_PUSH);
        o_job       = r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_job   <= n_job;
        if (r_state == FE_IDLE && w_accept) begin
            r_face <= n_face;
        end
        r_zero  <= n_zero;
        r_den   <= n_den;
        r_rem_u <= n_rem_u;
        r_rem_v <= n_rem_v;
        r_low_u <= n_low_u;
        r_low_v <= n_low_v;
        r_qu    <= n_qu;
        r_qv    <= n_qv;
        r_cnt   <= n_cnt;
    end

    `CMBS_ASSERT(a_quot_range, (r_state == FE_POS && !r_zero) |-> (r_qu <= 17'd65536 && r_qv <= 17'd65536), "face coordinate above 1.0")
    `CMBS_ASSERT(a_div_len, (r_state == FE_DIV && r_cnt == 5'd1) |=> (r_state == FE_POS), "divider did not finish")

endmodule

/* rtl/core/cmbs_fifo.sv */
// Two-entry job queue between the front and back ends.
`include "cube_map_bilinear_sampler_assert.svh"
module cmbs_fifo import cmbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `CMBS_NEVER(a_cnt_range, r_cnt == 2'd3, "queue count out of range")
    `CMBS_ASSERT(a_ptr_match, (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp), "queue pointers disagree with count")

endmodule

/* rtl/core/cmbs_back.sv */
// Back end: texel store, four-read bilinear blend and the result register.
`include "cube_map_bilinear_sampler_assert.svh"
module cmbs_back import cmbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_sample,
    output logic [2:0]  o_hit_face,
    output logic [16:0] o_u_coord,
    output logic [16:0] o_v_coord,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue
);

    logic [TEXEL_W-1:0] r_store [STORE_DEPTH];

    t_be_state r_state, n_state;
    t_job      r_job;
    logic [1:0]  r_k;
    logic        r_issue;
    logic        r_v1, r_l1, r_f1, r_v2, r_l2, r_f2;
    logic [32:0] r_w1;
    logic [TEXEL_W-1:0] r_rdata;
    logic [48:0] r_p2 [3];
    logic [48:0] r_acc [3];
    logic        r_out_valid;
    logic        r_is_sample;
    logic [2:0]  r_face;
    logic [16:0] r_u, r_v;
    logic [15:0] r_ch [3];

    logic        w_pop, w_issue, w_done, w_we;
    logic [4:0]  w_row, w_col, w_stride;
    logic [2:0]  w_face;
    logic [11:0] w_addr_full;
    logic [ADDR_W-1:0] w_addr;
    logic [16:0] w_wx, w_wy;
    logic [33:0] w_w;
    logic [48:0] w_sum [3];
    logic [48:0] w_rnd [3];

    assign w_pop   = (r_state == BE_IDLE) && i_job_valid && !r_out_valid;
    assign w_issue = (r_state == BE_RUN) && r_issue;
    assign w_done  = r_v2 && r_l2;
    assign w_we    = w_pop && !i_job.is_sample && i_job.wr_ok;

    // a write uses the incoming job, a read the held sample
    always_comb begin
        if (w_issue) begin
            w_face   = r_job.face;
            w_stride = r_job.stride;
            w_row    = r_job.y0 + 5'(r_k[1]);
            w_col    = r_job.x0 + 5'(r_k[0]);
        end else begin
            w_face   = i_job.face;
            w_stride = i_job.stride;
            w_row    = i_job.y0;
            w_col    = i_job.x0;
        end
        w_addr_full = (12'(w_face) * 12'(w_stride) + 12'(w_row)) * 12'(w_stride) + 12'(w_col);
        w_addr      = w_addr_full[ADDR_W-1:0];
    end

    always_comb begin
        w_wx = r_k[0] ? 17'(r_job.fx) : 17'd65536 - 17'(r_job.fx);
        w_wy = r_k[1] ? 17'(r_job.fy) : 17'd65536 - 17'(r_job.fy);
        w_w  = 34'(w_wx) * 34'(w_wy);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = (r_f2 ? 49'd0 : r_acc[c]) + r_p2[c];
            w_rnd[c] = w_sum[c] + 49'h0_8000_0000;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BE_IDLE: begin
                if (w_pop && i_job.is_sample) begin
                    n_state = BE_RUN;
                end
            end
            BE_RUN: begin
                if (w_done) begin
                    n_state = BE_IDLE;
                end
            end
            default: n_state = BE_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = w_pop;
        o_valid     = r_out_valid;
        o_is_sample = r_is_sample;
        o_hit_face  = r_face;
        o_u_coord   = r_u;
        o_v_coord   = r_v;
        o_red       = r_ch[0];
        o_green     = r_ch[1];
        o_blue      = r_ch[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_addr] <= i_job.texel;
        end
        r_rdata <= r_store[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BE_IDLE;
            r_issue     <= 1'b0;
            r_k         <= 2'd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            if (w_pop) begin
                r_issue <= i_job.is_sample;
                r_k     <= 2'd0;
            end else if (w_issue) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_issue <= 1'b0;
                end
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if ((w_pop && !i_job.is_sample) || w_done) begin
                r_out_valid <= 1'b1;
            end
        end
        if (w_pop) begin
            r_job <= i_job;
        end
        r_l1 <= (r_k == 2'd3);
        r_f1 <= (r_k == 2'd0);
        r_w1 <= w_w[32:0];
        r_l2 <= r_l1;
        r_f2 <= r_f1;
        for (int c = 0; c < 3; c++) begin
            r_p2[c] <= 49'(r_w1) * 49'(r_rdata[c*CH_BITS +: CH_BITS]);
            if (r_v2) begin
                r_acc[c] <= w_sum[c];
            end
        end
        // write acknowledge carries zeros
        if (w_pop && !i_job.is_sample) begin
            r_is_sample <= 1'b0;
            r_face      <= 3'd0;
            r_u         <= 17'd0;
            r_v         <= 17'd0;
            for (int c = 0; c < 3; c++) begin
                r_ch[c] <= 16'd0;
            end
        end else if (w_done) begin
            r_is_sample <= 1'b1;
            r_face      <= r_job.face;
            r_u         <= r_job.u;
            r_v         <= r_job.v;
            for (int c = 0; c < 3; c++) begin
                r_ch[c] <= w_rnd[c][47:32];
            end
        end
    end

    `CMBS_ASSERT(a_run_no_result, (r_state == BE_RUN) |-> !r_out_valid, "result pending during blend")
    `CMBS_NEVER(a_pop_while_busy, w_pop && r_out_valid, "job taken over a pending result")

endmodule

/* rtl/core/cube_map_bilinear_sampler.sv */
// Top level of the cube map bilinear sampler.
// Holds six faces of up to 16x16 texels plus a one-texel seam ring (1944 words of three
// 16-bit channels in one single-port memory). A transaction with tuser low writes one
// texel at a padded face position; one with tuser high samples toward a signed direction
// and returns the face, u and v in Q1.16 and the bilinear blend, rounded to nearest. Every
// transaction yields exactly one result, in order; a write result is an acknowledge with
// all fields zero. A sample passes the front end (accept, 17 steps of the shared
// two-lane restoring divider for u and v, position resolve, push) and then the back
// end (four texel reads from the single memory port, multiply and accumulate); the
// two ends overlap through a two-deep job queue. The front end takes a new request only
// after it has pushed the last job into the queue. The store is not cleared: the loader
// writes every texel, padding included, before sampling it.
// face_size may only be changed while no transaction is in flight.
module cube_map_bilinear_sampler import cmbs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [4:0]   i_cfg_wdata,   // face_size
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata, low bit up: write_face[3] write_col[5] write_row[5] write_red[16]
    // write_green[16] write_blue[16] dir_x[16] dir_y[16] dir_z[16], zero pad to 112
    input  logic [111:0] i_s_tdata,
    input  logic         i_s_tuser,     // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata, low bit up: hit_face[3] u_coord[17] v_coord[17] out_red[16]
    // out_green[16] out_blue[16], zero pad to 88
    output logic [87:0]  o_m_tdata,
    output logic         o_m_tuser      // is_sample
);

    logic [4:0]  r_face_size;
    logic        w_fe_valid, w_fe_ready, w_be_valid, w_be_ready;
    t_job        w_fe_job, w_be_job;
    logic [2:0]  w_face;
    logic [16:0] w_u, w_v;
    logic [15:0] w_red, w_green, w_blue;

    // configuration register, held until rewritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= 5'(MAX_FACE_SIZE);
        end else if (i_cfg_we) begin
            r_face_size <= i_cfg_wdata;
        end
    end

    cmbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_req_type   (i_s_tuser),
        .i_write_face (i_s_tdata[2:0]),
        .i_write_col  (i_s_tdata[7:3]),
        .i_write_row  (i_s_tdata[12:8]),
        .i_texel      (i_s_tdata[60:13]),
        .i_dir_x      (i_s_tdata[76:61]),
        .i_dir_y      (i_s_tdata[92:77]),
        .i_dir_z      (i_s_tdata[108:93]),
        .i_face_size  (r_face_size),
        .o_job_valid  (w_fe_valid),
        .i_job_ready  (w_fe_ready),
        .o_job        (w_fe_job)
    );

    // decouple classification from the memory side
    cmbs_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fe_valid),
        .o_ready (w_fe_ready),
        .i_job   (w_fe_job),
        .o_valid (w_be_valid),
        .i_ready (w_be_ready),
        .o_job   (w_be_job)
    );

    cmbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_be_valid),
        .o_job_ready (w_be_ready),
        .i_job       (w_be_job),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_is_sample (o_m_tuser),
        .o_hit_face  (w_face),
        .o_u_coord   (w_u),
        .o_v_coord   (w_v),
        .o_red       (w_red),
        .o_green     (w_green),
        .o_blue      (w_blue)
    );

    // pack result fields, lowest first
    assign o_m_tdata = {3'b000, w_blue, w_green, w_red, w_v, w_u, w_face};

endmodule
